/* hdl/gdr_pkg.sv */
// Shared types and constants of the grid DDA raycaster.
// Used by every module of the block; depends on nothing.
package gdr_pkg;

   // Field widths
   localparam int POS_W   = 22;
   localparam int ANG_W   = 12;
   localparam int FOV_W   = 11;
   localparam int SCR_W   = 12;
   localparam int CELL_W  = 6;
   localparam int COL_W   = 11;
   localparam int DIST_W  = 23;
   localparam int LH_W    = 16;
   localparam int ROW_W   = 11;
   localparam int SIN_W   = 18;
   localparam int CSR_W   = 22;
   localparam int CSR_IDX_W = 3;

   // Shared serial divider sizes
   localparam int DIV_N_W = 33;
   localparam int DIV_D_W = 23;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PLAYER_X  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PLAYER_Y  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PLAYER_A  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FOV       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_W  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_H  = 3'd5;

   // Commands
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_CAST  = 1'b1;

   // Fixed-point constants
   localparam logic [16:0] ONE_Q16   = 17'h10000;
   localparam logic [44:0] DELTA_SAT = 45'h1000_0000_0000;
   localparam logic [40:0] DIST_CAP  = 41'h100_0000_0000;
   localparam logic [22:0] DIST_MAX  = 23'h7F_FFFF;

   typedef struct packed {
      logic              command;
      logic [CELL_W-1:0] cell_x;
      logic [CELL_W-1:0] cell_y;
      logic              wall;
      logic [COL_W-1:0]  column;
   } req_type;

   typedef struct packed {
      logic [COL_W-1:0]  ray_column;
      logic              hit;
      logic              side;
      logic [CELL_W-1:0] hit_cell_x;
      logic [CELL_W-1:0] hit_cell_y;
      logic              step_x_negative;
      logic              step_y_negative;
      logic [DIST_W-1:0] raw_distance;
      logic [DIST_W-1:0] wall_distance;
      logic [LH_W-1:0]   slice_height;
      logic [ROW_W-1:0]  draw_start;
      logic [ROW_W-1:0]  draw_end;
   } rsp_type;

endpackage

/* hdl/grid_dda_raycaster_top.sv */
// Grid DDA raycaster top: sequencer, registers and the walk over the wall map.
// Instantiates gdr_map, gdr_sin and gdr_div; uses gdr_pkg.
//
//  channel   ports                          handshake
//  ------    -----------------------------  -------------------------------
//  request   start, busy, req_data          taken when start && !busy
//  result    rsp_valid, rsp_data            one-cycle strobe, cannot stall
//  config    csr_we, csr_index, csr_wdata   written when csr_we
//
// A map write leaves the block idle and gives no result.
// A cast keeps busy high until its walk ends, after at most MAX_STEPS cells, and
// strobes its result in the cycle after its last busy cycle. Its time is set by the
// shared divider, up to four divisions, and by the read-and-test loop of ST_STEP
// and ST_CHECK on the map memory for each cell walked.
// After reset the map is cleared, one cell a cycle, with busy high till every cell
// is clear. Results are strobed for one cycle and must be taken then.
module grid_dda_raycaster_top #(
   parameter int MAP_DIM   = 64,
   parameter int MAX_STEPS = 128
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  gdr_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   output gdr_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  logic [gdr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gdr_pkg::CSR_W-1:0]         csr_wdata
);
   import gdr_pkg::*;

   localparam int CW    = $clog2(MAP_DIM);
   localparam int XW    = (CW + 2 > 7) ? CW + 2 : 7;
   localparam int DEPTH = MAP_DIM * MAP_DIM;
   localparam int AW    = $clog2(DEPTH);
   localparam int NW    = $clog2(MAX_STEPS + 1);
   localparam int SDW   = 45 + $clog2(MAX_STEPS + 2);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_ANG, ST_SINX, ST_SINY, ST_SINC, ST_DELX, ST_DELY,
      ST_SIDE, ST_STEP, ST_CHECK, ST_WD, ST_LH, ST_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [1:0]         sub_ff, sub_in;
   logic [POS_W-1:0]   px_ff, px_in, py_ff, py_in;
   logic [ANG_W-1:0]   pa_ff, pa_in;
   logic [FOV_W-1:0]   fov_ff, fov_in;
   logic [SCR_W-1:0]   sw_ff, sw_in, sh_ff, sh_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ANG_W-1:0]   ang_ff, ang_in;
   logic signed [SIN_W-1:0] dx_ff, dx_in, dy_ff, dy_in, cs_ff, cs_in;
   logic [44:0]        ddx_ff, ddx_in, ddy_ff, ddy_in;
   logic [SDW-1:0]     sdx_ff, sdx_in, sdy_ff, sdy_in, dist_ff, dist_in;
   logic [XW-1:0]      mx_ff, mx_in, my_ff, my_in;
   logic               side_ff, side_in, hit_ff, hit_in;
   logic [NW-1:0]      n_ff, n_in;
   logic [40:0]        wd_ff, wd_in;
   logic [LH_W-1:0]    lh_ff, lh_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   // Unit connections
   logic               map_we, map_wdata, map_rdata, map_ready;
   logic [AW-1:0]      map_waddr, map_raddr;
   logic               sin_start, sin_done;
   logic [ANG_W-1:0]   sin_ang;
   logic signed [SIN_W-1:0] sin_val;
   logic               div_start, div_done;
   logic [DIV_N_W-1:0] div_n, div_q;
   logic [DIV_D_W-1:0] div_d;

   // Work signals
   logic               accept, dx_neg, dy_neg, take_x;
   logic [16:0]        fx, fy, fsel, mag;
   logic [24:0]        mul_a;
   logic [16:0]        mul_b;
   logic [41:0]        prod;
   logic [XW-1:0]      nx, ny, stp_x, stp_y;
   logic               off_map;
   logic [40:0]        dcap;
   logic [DIST_W-1:0]  wdc, raw;
   logic [10:0]        half, ds;
   logic [14:0]        lh2;
   logic [16:0]        de;

   gdr_map #(.DEPTH(DEPTH), .AW(AW)) u_map (
      .clock(clock), .reset(reset), .we(map_we), .waddr(map_waddr),
      .wdata(map_wdata), .raddr(map_raddr), .rdata(map_rdata), .ready(map_ready)
   );

   gdr_sin u_sin (
      .clock(clock), .reset(reset), .start(sin_start), .angle(sin_ang),
      .done(sin_done), .value(sin_val)
   );

   gdr_div #(.N_W(DIV_N_W), .D_W(DIV_D_W)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_n),
      .divisor(div_d), .done(div_done), .quotient(div_q)
   );

   always_comb begin
      accept = start && (state_ff == ST_IDLE);
      dx_neg = dx_ff < 0;
      dy_neg = dy_ff < 0;
      fx = dx_neg ? {1'b0, px_ff[15:0]} : (ONE_Q16 - {1'b0, px_ff[15:0]});
      fy = dy_neg ? {1'b0, py_ff[15:0]} : (ONE_Q16 - {1'b0, py_ff[15:0]});
      mag = (state_ff == ST_DELX) ? (dx_neg ? 17'(-dx_ff) : dx_ff[16:0])
                                  : (dy_neg ? 17'(-dy_ff) : dy_ff[16:0]);

      // Walk step: pick the nearer grid line
      take_x = sdx_ff < sdy_ff;
      stp_x  = dx_neg ? {XW{1'b1}} : XW'(1);
      stp_y  = dy_neg ? {XW{1'b1}} : XW'(1);
      nx = take_x ? mx_ff + stp_x : mx_ff;
      ny = take_x ? my_ff : my_ff + stp_y;
      off_map = nx[XW-1] || ny[XW-1] || (nx >= XW'(MAP_DIM)) || (ny >= XW'(MAP_DIM));

      // Distance clamps
      dcap = (dist_ff > SDW'(DIST_CAP)) ? DIST_CAP : dist_ff[40:0];
      raw  = (dist_ff > SDW'(DIST_MAX)) ? DIST_MAX : dist_ff[DIST_W-1:0];
      wdc  = (wd_ff > 41'(DIST_MAX)) ? DIST_MAX : wd_ff[DIST_W-1:0];

      // Shared multiplier
      fsel = (sub_ff[1]) ? fy : fx;
      mul_a = '0;
      mul_b = '0;
      if (state_ff == ST_SIDE) begin
         mul_b = fsel;
         case (sub_ff)
            2'd0:    mul_a = 25'(ddx_ff[15:0]);
            2'd1:    mul_a = 25'(ddx_ff[32:16]);
            2'd2:    mul_a = 25'(ddy_ff[15:0]);
            default: mul_a = 25'(ddy_ff[32:16]);
         endcase
      end else if (state_ff == ST_WD) begin
         mul_b = cs_ff[16:0];
         mul_a = sub_ff[0] ? dcap[40:16] : 25'(dcap[15:0]);
      end
      prod = 42'(mul_a) * 42'(mul_b);

      // Slice bounds
      half = sh_ff[11:1];
      lh2  = lh_ff[15:1];
      ds   = (15'(half) > lh2) ? (half - lh2[10:0]) : 11'd0;
      de   = 17'(lh2) + 17'(half);
      if (de >= 17'(sh_ff)) begin
         de = 17'(sh_ff) - 17'd1;
      end
      if (de > 17'd2047) begin
         de = 17'd2047;
      end

      // Map port
      map_we    = accept && (req_data.command == CMD_WRITE)
                  && (32'(req_data.cell_x) < MAP_DIM) && (32'(req_data.cell_y) < MAP_DIM);
      map_waddr = AW'(32'(req_data.cell_y) * MAP_DIM + 32'(req_data.cell_x));
      map_wdata = req_data.wall;
      map_raddr = AW'(32'(ny[XW-2:0]) * MAP_DIM + 32'(nx[XW-2:0]));

      // Defaults: hold
      state_in = state_ff;
      sub_in   = sub_ff;
      px_in = px_ff; py_in = py_ff; pa_in = pa_ff;
      fov_in = fov_ff; sw_in = sw_ff; sh_in = sh_ff;
      col_in = col_ff; ang_in = ang_ff;
      dx_in = dx_ff; dy_in = dy_ff; cs_in = cs_ff;
      ddx_in = ddx_ff; ddy_in = ddy_ff;
      sdx_in = sdx_ff; sdy_in = sdy_ff; dist_in = dist_ff;
      mx_in = mx_ff; my_in = my_ff;
      side_in = side_ff; hit_in = hit_ff; n_in = n_ff;
      wd_in = wd_ff; lh_in = lh_ff;
      rsp_valid_in = 1'b0;
      rsp_in = rsp_ff;
      sin_start = 1'b0;
      sin_ang   = ang_ff;
      div_start = 1'b0;
      div_n     = '0;
      div_d     = '0;

      // Register writes
      if (csr_we) begin
         unique case (csr_index)
            CSR_PLAYER_X: px_in  = csr_wdata;
            CSR_PLAYER_Y: py_in  = csr_wdata;
            CSR_PLAYER_A: pa_in  = csr_wdata[ANG_W-1:0];
            CSR_FOV:      fov_in = csr_wdata[FOV_W-1:0];
            CSR_SCREEN_W: sw_in  = csr_wdata[SCR_W-1:0];
            CSR_SCREEN_H: sh_in  = csr_wdata[SCR_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            if (map_ready) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && req_data.command == CMD_CAST) begin
               col_in  = req_data.column;
               mx_in   = XW'(px_ff[21:16]);
               my_in   = XW'(py_ff[21:16]);
               side_in = 1'b0;
               hit_in  = 1'b0;
               dist_in = '0;
               n_in    = '0;
               sub_in  = 2'd0;
               state_in = ST_ANG;
            end
         end
         ST_ANG: begin
            div_n = DIV_N_W'(col_ff) * DIV_N_W'(fov_ff);
            div_d = (sw_ff == '0) ? DIV_D_W'(1) : DIV_D_W'(sw_ff);
            div_start = (sub_ff == 2'd0);
            sub_in = 2'd1;
            if (div_done) begin
               ang_in = pa_ff - ANG_W'(fov_ff >> 1) + div_q[ANG_W-1:0];
               sub_in = 2'd0;
               state_in = ST_SINX;
            end
         end
         ST_SINX, ST_SINY, ST_SINC: begin
            // Cosine is the sine a quarter turn on
            if (state_ff == ST_SINX) begin
               sin_ang = ang_ff + ANG_W'(1024);
            end else if (state_ff == ST_SINC) begin
               sin_ang = ang_ff - pa_ff + ANG_W'(1024);
            end
            sin_start = (sub_ff == 2'd0);
            sub_in = 2'd1;
            if (sin_done) begin
               sub_in = 2'd0;
               if (state_ff == ST_SINX) begin
                  dx_in = sin_val;
                  state_in = ST_SINY;
               end else if (state_ff == ST_SINY) begin
                  dy_in = sin_val;
                  state_in = ST_SINC;
               end else begin
                  cs_in = sin_val;
                  state_in = ST_DELX;
               end
            end
         end
         ST_DELX, ST_DELY: begin
            div_n = DIV_N_W'(34'h1_0000_0000);
            div_d = DIV_D_W'(mag);
            if (mag == '0) begin
               // Zero direction: saturate the step size
               if (state_ff == ST_DELX) begin
                  ddx_in = DELTA_SAT;
                  state_in = ST_DELY;
               end else begin
                  ddy_in = DELTA_SAT;
                  state_in = ST_SIDE;
               end
            end else begin
               div_start = (sub_ff == 2'd0);
               sub_in = 2'd1;
               if (div_done) begin
                  sub_in = 2'd0;
                  if (state_ff == ST_DELX) begin
                     ddx_in = 45'(div_q);
                     state_in = ST_DELY;
                  end else begin
                     ddy_in = 45'(div_q);
                     state_in = ST_SIDE;
                  end
               end
            end
         end
         ST_SIDE: begin
            // Initial side distances from the partial products
            sub_in = sub_ff + 2'd1;
            case (sub_ff)
               2'd0: sdx_in = SDW'(prod[41:16]);
               2'd1: sdx_in = ddx_ff[44] ? SDW'({fx, 28'b0}) : sdx_ff + SDW'(prod);
               2'd2: sdy_in = SDW'(prod[41:16]);
               default: begin
                  sdy_in = ddy_ff[44] ? SDW'({fy, 28'b0}) : sdy_ff + SDW'(prod);
                  if ((32'(mx_ff) < MAP_DIM) && (32'(my_ff) < MAP_DIM)) begin
                     state_in = ST_STEP;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
            endcase
         end
         ST_STEP: begin
            if (n_ff == NW'(MAX_STEPS)) begin
               state_in = ST_DONE;
            end else begin
               n_in = n_ff + NW'(1);
               if (take_x) begin
                  dist_in = sdx_ff;
                  sdx_in  = sdx_ff + SDW'(ddx_ff);
                  side_in = 1'b0;
               end else begin
                  dist_in = sdy_ff;
                  sdy_in  = sdy_ff + SDW'(ddy_ff);
                  side_in = 1'b1;
               end
               mx_in = nx;
               my_in = ny;
               state_in = off_map ? ST_DONE : ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (map_rdata) begin
               hit_in = 1'b1;
               sub_in = 2'd0;
               state_in = ST_WD;
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_WD: begin
            // Fisheye correction over two partial products
            if (cs_ff <= 0) begin
               wd_in = '0;
               sub_in = 2'd0;
               state_in = ST_LH;
            end else if (sub_ff == 2'd0) begin
               wd_in = 41'(prod[41:16]);
               sub_in = 2'd1;
            end else begin
               wd_in = wd_ff + prod[40:0];
               sub_in = 2'd0;
               state_in = ST_LH;
            end
         end
         ST_LH: begin
            div_n = DIV_N_W'({sh_ff, 16'b0});
            div_d = wdc;
            if (wdc == '0) begin
               lh_in = '1;
               state_in = ST_DONE;
            end else begin
               div_start = (sub_ff == 2'd0);
               sub_in = 2'd1;
               if (div_done) begin
                  lh_in = (|div_q[DIV_N_W-1:16]) ? '1 : div_q[15:0];
                  sub_in = 2'd0;
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            rsp_in.ray_column      = col_ff;
            rsp_in.hit             = hit_ff;
            rsp_in.side            = side_ff;
            rsp_in.step_x_negative = dx_neg;
            rsp_in.step_y_negative = dy_neg;
            rsp_in.hit_cell_x      = '0;
            rsp_in.hit_cell_y      = '0;
            rsp_in.raw_distance    = '0;
            rsp_in.wall_distance   = '0;
            rsp_in.slice_height    = '0;
            rsp_in.draw_start      = '0;
            rsp_in.draw_end        = '0;
            if (hit_ff) begin
               rsp_in.hit_cell_x    = mx_ff[CELL_W-1:0];
               rsp_in.hit_cell_y    = my_ff[CELL_W-1:0];
               rsp_in.raw_distance  = raw;
               rsp_in.wall_distance = wdc;
               rsp_in.slice_height  = lh_ff;
               if (sh_ff != '0) begin
                  rsp_in.draw_start = ds;
                  rsp_in.draw_end   = de[ROW_W-1:0];
               end
            end
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      col_ff <= col_in;  ang_ff <= ang_in;
      dx_ff <= dx_in;    dy_ff <= dy_in;    cs_ff <= cs_in;
      ddx_ff <= ddx_in;  ddy_ff <= ddy_in;
      sdx_ff <= sdx_in;  sdy_ff <= sdy_in;  dist_ff <= dist_in;
      mx_ff <= mx_in;    my_ff <= my_in;
      side_ff <= side_in; hit_ff <= hit_in; n_ff <= n_in;
      wd_ff <= wd_in;    lh_ff <= lh_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sub_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
         px_ff  <= POS_W'(2129920);
         py_ff  <= POS_W'(2129920);
         pa_ff  <= '0;
         fov_ff <= FOV_W'(683);
         sw_ff  <= SCR_W'(640);
         sh_ff  <= SCR_W'(480);
      end else begin
         state_ff     <= state_in;
         sub_ff       <= sub_in;
         rsp_valid_ff <= rsp_valid_in;
         px_ff  <= px_in;
         py_ff  <= py_in;
         pa_ff  <= pa_in;
         fov_ff <= fov_in;
         sw_ff  <= sw_in;
         sh_ff  <= sh_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* hdl/gdr_map.sv */
// Wall map memory: one bit per cell, synchronous write and registered read.
// Clears itself after reset, one entry per cycle. Uses gdr_pkg.
module gdr_map #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic          wdata,
   input  logic [AW-1:0] raddr,
   output logic          rdata,
   output logic          ready
);
   import gdr_pkg::*;

   logic          map_mem [DEPTH];
   logic [AW-1:0] clr_ff, clr_in;
   logic          clearing_ff, clearing_in;
   logic          rdata_ff;

   // Advance the clearing pass
   always_comb begin
      clr_in      = clr_ff;
      clearing_in = clearing_ff;
      if (clearing_ff) begin
         clr_in = clr_ff + AW'(1);
         if (clr_ff == AW'(DEPTH - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= '0;
         clearing_ff <= 1'b1;
      end else begin
         clr_ff      <= clr_in;
         clearing_ff <= clearing_in;
      end
   end

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         map_mem[clr_ff] <= 1'b0;
      end else if (we) begin
         map_mem[waddr] <= wdata;
      end
      rdata_ff <= map_mem[raddr];
   end

   assign rdata = rdata_ff;
   assign ready = !clearing_ff;

endmodule

/* hdl/gdr_sin.sv */
// Sine unit: quarter-wave folding and an odd polynomial, one multiply a cycle.
// Six multiplies per value. Uses gdr_pkg.
module gdr_sin (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [gdr_pkg::ANG_W-1:0]         angle,
   output logic                              done,
   output logic signed [gdr_pkg::SIN_W-1:0]  value
);
   import gdr_pkg::*;

   localparam logic [16:0] COEF [4] = '{17'd307, 17'd5223, 17'd42334, 17'd102944};

   logic              run_ff, run_in;
   logic [2:0]        k_ff, k_in;
   logic [16:0]       t_ff, t_in;
   logic [16:0]       t2_ff, t2_in;
   logic [16:0]       p_ff, p_in;
   logic              neg_ff, neg_in;
   logic              done_ff, done_in;
   logic [SIN_W-1:0]  value_ff, value_in;
   logic [10:0]       u;
   logic [16:0]       mul_a, mul_b;
   logic [33:0]       prod;
   logic [17:0]       sh;
   logic [16:0]       mag;

   always_comb begin
      // Fold the angle into the first quarter
      u = angle[10] ? (11'd1024 - {1'b0, angle[9:0]}) : {1'b0, angle[9:0]};
      mul_a = (k_ff == 3'd0 || k_ff == 3'd5) ? t_ff : t2_ff;
      mul_b = (k_ff == 3'd0) ? t_ff : p_ff;
      prod  = 34'(mul_a) * 34'(mul_b);
      sh    = prod[33:16];
      mag   = (sh > 18'(ONE_Q16)) ? ONE_Q16 : sh[16:0];

      run_in   = run_ff;
      k_in     = k_ff;
      t_in     = t_ff;
      t2_in    = t2_ff;
      p_in     = p_ff;
      neg_in   = neg_ff;
      done_in  = 1'b0;
      value_in = value_ff;

      if (start && !run_ff) begin
         t_in   = {u, 6'b0};
         neg_in = angle[11];
         k_in   = 3'd0;
         run_in = 1'b1;
      end else if (run_ff) begin
         k_in = k_ff + 3'd1;
         case (k_ff)
            3'd0: begin
               t2_in = sh[16:0];
               p_in  = 17'd11;
            end
            3'd1, 3'd2, 3'd3, 3'd4: begin
               p_in = COEF[2'(k_ff - 3'd1)] - sh[16:0];
            end
            default: begin
               value_in = neg_ff ? (SIN_W'(0) - {1'b0, mag}) : {1'b0, mag};
               done_in  = 1'b1;
               run_in   = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      t_ff     <= t_in;
      t2_ff    <= t2_in;
      p_ff     <= p_in;
      neg_ff   <= neg_in;
      k_ff     <= k_in;
      value_ff <= value_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done  = done_ff;
   assign value = $signed(value_ff);

endmodule

/* hdl/gdr_div.sv */
// Restoring divider, one quotient bit per cycle.
// Shared by angle, step size and slice height. Uses gdr_pkg.
module gdr_div #(
   parameter int N_W = 33,
   parameter int D_W = 23
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [N_W-1:0] dividend,
   input  logic [D_W-1:0] divisor,
   output logic           done,
   output logic [N_W-1:0] quotient
);
   import gdr_pkg::*;

   localparam int CNT_W = $clog2(N_W + 1);

   logic             run_ff, run_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [D_W-1:0]   rem_ff, rem_in;
   logic [N_W-1:0]   quo_ff, quo_in;
   logic [D_W-1:0]   dsr_ff, dsr_in;
   logic             done_ff, done_in;
   logic [D_W:0]     trial;
   logic             fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[N_W-1]};
      fits    = trial >= {1'b0, dsr_ff};
      run_in  = run_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      done_in = 1'b0;
      if (start && !run_ff) begin
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         quo_in = dividend;
         dsr_in = divisor;
      end else if (run_ff) begin
         // Shift in one dividend bit, subtract when it fits
         rem_in = fits ? D_W'(trial - {1'b0, dsr_ff}) : D_W'(trial);
         quo_in = {quo_ff[N_W-2:0], fits};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(N_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* hdl/gdr_checker.sv */
// Port-level checks for the raycaster, bound to the top level.
// Uses gdr_pkg.
module gdr_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input gdr_pkg::req_type req_data,
   input logic             rsp_valid,
   input gdr_pkg::rsp_type rsp_data
);
   import gdr_pkg::*;

   // Map clearing holds off items after reset
   a_clear_after_reset: assert property (@(posedge clock) reset |=> busy)
      else $error("not busy after reset");

   // A result strobe lasts one cycle
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // A map write finishes at once
   a_write_fast: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.command == CMD_WRITE) |=> (!busy && !rsp_valid))
      else $error("map write did not finish in one cycle");

   // A cast keeps the block busy
   a_cast_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.command == CMD_CAST) |=> busy)
      else $error("cast did not start");

   // A miss reports no distances
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.hit) |-> (rsp_data.raw_distance == '0
         && rsp_data.slice_height == '0 && rsp_data.draw_end == '0))
      else $error("miss with nonzero distance");

endmodule

bind grid_dda_raycaster_top gdr_checker u_chk (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
);
